// ----- rtl/core/ultrasonic_echo_ranger_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic echo ranger
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define UER_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("echo ranger: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define UER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("echo ranger: next-cycle check failed");

`endif

// ----- rtl/core/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants shared by the ultrasonic echo ranger modules.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // Width of the elapsed and travel time counters.
  localparam int unsigned TIME_BITS  = 16;
  localparam int unsigned TRIG_W     = 8;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned LOWRUN_W   = 8;
  localparam int unsigned DIST_W     = 11;

  // Compare width for travel time against the timeout register.
  localparam int unsigned CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

  // Division by 58 is done as a multiply by a rounded-up reciprocal. With
  // seven extra fraction bits the error stays below one for every time value.
  localparam int unsigned CM_DIVISOR = 58;
  localparam int unsigned DIV_SHIFT  = TIME_BITS + 7;
  localparam int unsigned RECIP_W    = TIME_BITS + 2;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << DIV_SHIFT) + 64'(CM_DIVISOR) - 64'd1) / 64'(CM_DIVISOR);
  localparam logic [RECIP_W-1:0] CM_RECIP = RECIP_VAL[RECIP_W-1:0];
  localparam int unsigned PROD_W =
    ((TIME_BITS + RECIP_W) > (DIV_SHIFT + DIST_W)) ?
    (TIME_BITS + RECIP_W) : (DIV_SHIFT + DIST_W);

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_TRIGGER_TICKS = 2'd0,
    REG_TIMEOUT_TICKS = 2'd1,
    REG_LOW_RUN_TICKS = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  localparam logic [TRIG_W-1:0]    TRIGGER_TICKS_RST = 8'd20;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 16'd19140;
  localparam logic [LOWRUN_W-1:0]  LOW_RUN_TICKS_RST = 8'd30;

  typedef struct packed {
    logic [TRIG_W-1:0]    trigger_ticks;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [LOWRUN_W-1:0]  low_run_ticks;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo;
  } in_item_t;

  typedef struct packed {
    logic              trigger;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [DIST_W-1:0] distance_cm;
  } out_item_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_WAIT = 5'b00100,
    PH_HIGH = 5'b01000,
    PH_LOW  = 5'b10000
  } phase_e;

endpackage

`default_nettype wire

// ----- rtl/core/uer_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// uer_cfg_regs
// APB-style register file holding trigger length, timeout and low run length.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [uer_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [uer_pkg::PDATA_W-1:0]   pwdata,
  output logic      [uer_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output uer_pkg::cfg_t                      cfg_o
);

  uer_pkg::cfg_t    cfg_q, cfg_d;
  uer_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = uer_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        uer_pkg::REG_TRIGGER_TICKS: cfg_d.trigger_ticks = pwdata[uer_pkg::TRIG_W-1:0];
        uer_pkg::REG_TIMEOUT_TICKS: cfg_d.timeout_ticks = pwdata[uer_pkg::TIMEOUT_W-1:0];
        uer_pkg::REG_LOW_RUN_TICKS: cfg_d.low_run_ticks = pwdata[uer_pkg::LOWRUN_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      uer_pkg::REG_TRIGGER_TICKS:
        prdata[uer_pkg::TRIG_W-1:0] = cfg_q.trigger_ticks;
      uer_pkg::REG_TIMEOUT_TICKS:
        prdata[uer_pkg::TIMEOUT_W-1:0] = cfg_q.timeout_ticks;
      uer_pkg::REG_LOW_RUN_TICKS:
        prdata[uer_pkg::LOWRUN_W-1:0] = cfg_q.low_run_ticks;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= uer_pkg::TRIGGER_TICKS_RST;
      cfg_q.timeout_ticks <= uer_pkg::TIMEOUT_TICKS_RST;
      cfg_q.low_run_ticks <= uer_pkg::LOW_RUN_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/uer_core.sv -----
// ----------------------------------------------------------------------------
// uer_core
// Measurement sequencer: advances the phase and timers by one tick per item
// and forms that tick's result, including the distance in centimeters.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire uer_pkg::in_item_t item_i,
  input  wire uer_pkg::cfg_t     cfg_i,
  output uer_pkg::out_item_t     result_o
);

  uer_pkg::phase_e                  phase_q, phase_d;
  logic [uer_pkg::TRIG_W-1:0]       pulse_q, pulse_d;
  logic [uer_pkg::TIME_BITS-1:0]    elapsed_q, elapsed_d;
  logic [uer_pkg::TIME_BITS-1:0]    travel_q, travel_d;
  logic [uer_pkg::LOWRUN_W-1:0]     low_q, low_d;
  logic                             high_seen;
  logic                             done;
  logic                             tmo;
  logic                             trig;
  logic [uer_pkg::CMP_W-1:0]        travel_cmp;
  logic [uer_pkg::CMP_W-1:0]        timeout_cmp;
  logic [uer_pkg::PROD_W-1:0]       travel_ext;
  logic [uer_pkg::PROD_W-1:0]       recip_ext;
  logic [uer_pkg::PROD_W-1:0]       product;

  always_comb begin
    phase_d   = phase_q;
    pulse_d   = pulse_q;
    elapsed_d = elapsed_q;
    travel_d  = travel_q;
    low_d     = low_q;
    high_seen = 1'b0;
    done      = 1'b0;
    trig      = 1'b0;

    unique case (phase_q)
      uer_pkg::PH_IDLE: begin
        if (item_i.start_req) begin
          phase_d = uer_pkg::PH_TRIG;
          pulse_d = '0;
        end
      end
      uer_pkg::PH_TRIG: begin
        phase_d = uer_pkg::PH_TRIG;
      end
      uer_pkg::PH_WAIT: begin
        if (item_i.echo) begin
          elapsed_d = '0;
          travel_d  = '0;
          low_d     = '0;
          phase_d   = uer_pkg::PH_HIGH;
          high_seen = 1'b1;
        end
      end
      uer_pkg::PH_HIGH, uer_pkg::PH_LOW: begin
        elapsed_d = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
        if (item_i.echo) begin
          travel_d  = elapsed_d;
          low_d     = '0;
          phase_d   = uer_pkg::PH_HIGH;
          high_seen = 1'b1;
        end else begin
          low_d   = (low_q == '1) ? low_q : low_q + 1'b1;
          phase_d = uer_pkg::PH_LOW;
          done    = (low_d >= cfg_i.low_run_ticks);
        end
      end
      default: begin
        phase_d = uer_pkg::PH_IDLE;
      end
    endcase

    // The trigger tick count includes the tick that started the measurement.
    if (phase_d == uer_pkg::PH_TRIG) begin
      trig    = 1'b1;
      pulse_d = pulse_d + 1'b1;
      if (pulse_d >= cfg_i.trigger_ticks) begin
        phase_d = uer_pkg::PH_WAIT;
      end
    end

    travel_cmp = {{(uer_pkg::CMP_W - uer_pkg::TIME_BITS){1'b0}}, travel_d};
    tmo = high_seen && (travel_cmp >= timeout_cmp);
    if (tmo) begin
      done = 1'b1;
    end

    if (done) begin
      phase_d = uer_pkg::PH_IDLE;
      pulse_d = '0;
      low_d   = '0;
    end
  end

  assign timeout_cmp = {{(uer_pkg::CMP_W - uer_pkg::TIMEOUT_W){1'b0}}, cfg_i.timeout_ticks};

  assign travel_ext = {{(uer_pkg::PROD_W - uer_pkg::TIME_BITS){1'b0}}, travel_d};
  assign recip_ext  = {{(uer_pkg::PROD_W - uer_pkg::RECIP_W){1'b0}}, uer_pkg::CM_RECIP};
  assign product    = travel_ext * recip_ext;

  assign result_o.trigger     = trig;
  assign result_o.busy_res    = (phase_d != uer_pkg::PH_IDLE);
  assign result_o.done_res    = done;
  assign result_o.timed_out   = tmo;
  assign result_o.distance_cm =
    done ? product[uer_pkg::DIV_SHIFT +: uer_pkg::DIST_W] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= uer_pkg::PH_IDLE;
      pulse_q   <= '0;
      elapsed_q <= '0;
      travel_q  <= '0;
      low_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pulse_q   <= pulse_d;
      elapsed_q <= elapsed_d;
      travel_q  <= travel_d;
      low_q     <= low_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/uer_out_buf.sv -----
// ----------------------------------------------------------------------------
// uer_out_buf
// Output register with a skid stage, so the input side never waits on a
// combinational path from the output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_out_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire uer_pkg::out_item_t push_data_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output uer_pkg::out_item_t      out_data_o
);

  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  uer_pkg::out_item_t out_data_q, out_data_d;
  uer_pkg::out_item_t skid_data_q, skid_data_d;
  logic               out_free;

  // The output register can load when empty or when its request leaves now.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Ultrasonic echo-ranging controller, one input request per microsecond tick.
// Each input request carries a start request and the sampled echo level; each
// one produces exactly one output request with the trigger level, busy, done,
// timeout flag and the distance in centimeters (echo time divided by 58).
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. An accepted result is registered in the output register, or
// in the skid stage while that register holds a stalled item; one item is
// taken every cycle while the output drains. The tick step and divide-by-58
// multiply sit between the input and the output register. The skid stage
// absorbs one item on a receiver stall; input stall rises only when it is full.
// Reset clears the sequencer to idle, empties the output stages and loads
// the registers with trigger 20, timeout 19140 and low run 30 ticks.
// Registers are written through the APB-style port at byte addresses 0, 4, 8.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire uer_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output uer_pkg::out_item_t                 out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [uer_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [uer_pkg::PDATA_W-1:0]   pwdata,
  output logic      [uer_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  uer_pkg::cfg_t      cfg;
  uer_pkg::out_item_t result;
  logic               accept;
  logic               buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  uer_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  uer_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg),
    .result_o (result)
  );

  uer_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `UER_ASSERT_SAME(a_done_ends_busy, out_valid_o && out_data_o.done_res, !out_data_o.busy_res)
  `UER_ASSERT_SAME(a_timeout_with_done, out_valid_o && out_data_o.timed_out, out_data_o.done_res)
  `UER_ASSERT_SAME(a_skid_needs_out, in_stall_o, out_valid_o)
  `UER_ASSERT_NEXT(a_accept_shows, in_valid_i && !in_stall_o, out_valid_o)

endmodule

`default_nettype wire
